@@ sv/spwm_pkg.sv @@
// shared codes, types and secded helper functions for the protected word memory
package spwm_pkg;

    localparam int WORDS_DEFAULT = 1024;

    localparam int DATA_W  = 32;
    localparam int CHECK_W = 7;
    localparam int CW_W    = DATA_W + CHECK_W;
    localparam int SYN_W   = 6;

    localparam logic [2:0] KIND_WR_WORD = 3'd0;
    localparam logic [2:0] KIND_WR_HALF = 3'd1;
    localparam logic [2:0] KIND_WR_BYTE = 3'd2;
    localparam logic [2:0] KIND_RD_WORD = 3'd3;
    localparam logic [2:0] KIND_RD_HALF = 3'd4;
    localparam logic [2:0] KIND_RD_BYTE = 3'd5;
    localparam logic [2:0] KIND_RAW     = 3'd6;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISALIGN = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    localparam logic [SYN_W-1:0] SYN_MAX = 6'd38;

    localparam logic [SYN_W-1:0] HAM_POS [DATA_W] = '{
        6'd3,  6'd5,  6'd6,  6'd7,  6'd9,  6'd10, 6'd11, 6'd12,
        6'd13, 6'd14, 6'd15, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd30, 6'd31, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38
    };

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic [CW_W-1:0]   codeword;
        logic              corrected;
        logic              detected;
    } spwm_codec_t;

    function automatic logic [SYN_W-1:0] ham_bits(input logic [DATA_W-1:0] d);
        logic [SYN_W-1:0] h;
        h = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (d[i]) begin
                h = h ^ HAM_POS[i];
            end
        end
        return h;
    endfunction

    function automatic logic [CW_W-1:0] encode(input logic [DATA_W-1:0] d);
        logic [SYN_W-1:0] h;
        logic             p;
        h = ham_bits(d);
        p = (^d) ^ (^h);
        return {p, h, d};
    endfunction

endpackage

@@ sv/spwm_codec.sv @@
// secded decode, sub-word merge and re-encode of one stored codeword
module spwm_codec (
    input  logic [spwm_pkg::CW_W-1:0]   codeword,
    input  logic [2:0]                  kind,
    input  logic [1:0]                  offset,
    input  logic [spwm_pkg::DATA_W-1:0] wdata,
    input  logic [spwm_pkg::CHECK_W-1:0] raw_check,
    output spwm_pkg::spwm_codec_t       result
);
    import spwm_pkg::*;

    logic [DATA_W-1:0] stored_data;
    logic [SYN_W-1:0]  stored_ham;
    logic              stored_par;
    logic [SYN_W-1:0]  syn;
    logic              odd;
    logic [DATA_W-1:0] flip;
    logic [DATA_W-1:0] fixed;
    logic [DATA_W-1:0] merged;
    logic              cor;
    logic              det;

    assign stored_data = codeword[DATA_W-1:0];
    assign stored_ham  = codeword[DATA_W+SYN_W-1:DATA_W];
    assign stored_par  = codeword[CW_W-1];
    assign syn         = ham_bits(stored_data) ^ stored_ham;
    assign odd         = (^stored_data) ^ (^stored_ham) ^ stored_par;

    always_comb begin
        for (int i = 0; i < DATA_W; i++) begin
            flip[i] = (HAM_POS[i] == syn);
        end
    end

    always_comb begin
        cor   = 1'b0;
        det   = 1'b0;
        fixed = stored_data;
        if (syn != '0 || odd) begin
            if (!odd || syn > SYN_MAX) begin
                det = 1'b1;
            end else begin
                cor   = 1'b1;
                fixed = stored_data ^ flip;
            end
        end
    end

    always_comb begin
        merged = fixed;
        case (kind)
            KIND_WR_WORD: merged = wdata;
            KIND_WR_HALF: begin
                if (offset[1]) begin
                    merged[31:16] = wdata[15:0];
                end else begin
                    merged[15:0] = wdata[15:0];
                end
            end
            KIND_WR_BYTE: begin
                case (offset)
                    2'd0:    merged[7:0]   = wdata[7:0];
                    2'd1:    merged[15:8]  = wdata[7:0];
                    2'd2:    merged[23:16] = wdata[7:0];
                    default: merged[31:24] = wdata[7:0];
                endcase
            end
            default: merged = fixed;
        endcase
    end

    always_comb begin
        result.corrected = cor;
        result.detected  = det;
        if (kind == KIND_RAW) begin
            result.codeword = {raw_check, wdata};
        end else begin
            result.codeword = encode(merged);
        end
        case (kind)
            KIND_RD_WORD: result.rdata = fixed;
            KIND_RD_HALF: result.rdata = {16'd0, offset[1] ? fixed[31:16] : fixed[15:0]};
            KIND_RD_BYTE: begin
                case (offset)
                    2'd0:    result.rdata = {24'd0, fixed[7:0]};
                    2'd1:    result.rdata = {24'd0, fixed[15:8]};
                    2'd2:    result.rdata = {24'd0, fixed[23:16]};
                    default: result.rdata = {24'd0, fixed[31:24]};
                endcase
            end
            default: result.rdata = '0;
        endcase
    end

endmodule

@@ sv/secded_protected_word_memory_core.sv @@
// top level of the secded protected word memory: control, codeword ram, counters
// result word: registered from the EXEC state once the output register is free
// one word at a time: s_tready is low in EXEC, while the ram read is decoded and written back
// reset: counters cleared, then a clearing pass zeroes all WORDS ram entries
// with s_tready low; the output register may hold one result while the next word is taken
module secded_protected_word_memory_core #(
    parameter int WORDS = spwm_pkg::WORDS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // addr, wdata, raw_check, zero pad
    input  logic [2:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // rdata, status, corrected, detected,
                                    // correction_total, detection_total, zero pad
);
    import spwm_pkg::*;

    localparam int AW = $clog2(WORDS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [AW-1:0]       clr_idx_reg, clr_idx_next;

    logic [2:0]          kind_reg, kind_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [1:0]          off_reg, off_next;
    logic [DATA_W-1:0]   wdata_reg, wdata_next;
    logic [CHECK_W-1:0]  raw_reg, raw_next;
    logic [1:0]          status_reg, status_next;

    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   rdata_reg, rdata_next;
    logic [1:0]          ostat_reg, ostat_next;
    logic                cor_reg, cor_next;
    logic                det_reg, det_next;
    logic [31:0]         cor_cnt_reg, cor_cnt_next;
    logic [31:0]         det_cnt_reg, det_cnt_next;

    logic [CW_W-1:0]     mem [WORDS];
    logic [CW_W-1:0]     rd_data_reg;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [CW_W-1:0]     mem_wdata;

    logic [2:0]          in_kind;
    logic [31:0]         in_addr;
    logic                misalign;
    logic                beyond;
    logic [1:0]          in_status;
    logic                accept;
    logic                out_free;
    logic                exec_fire;
    logic                ok;
    logic                is_decode;
    logic                is_write;
    logic                is_read;

    spwm_codec_t         codec;

    assign in_kind  = s_tuser;
    assign in_addr  = s_tdata[31:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign exec_fire = (state_reg == ST_EXEC) && out_free;

    always_comb begin
        misalign = 1'b0;
        if (in_kind inside {KIND_WR_WORD, KIND_RD_WORD, KIND_RAW}) begin
            misalign = (in_addr[1:0] != 2'd0);
        end else if (in_kind inside {KIND_WR_HALF, KIND_RD_HALF}) begin
            misalign = in_addr[0];
        end
        beyond = ({2'b00, in_addr[31:2]} >= 32'(WORDS)) && (in_kind <= KIND_RAW);
        if (misalign) begin
            in_status = STATUS_MISALIGN;
        end else if (beyond) begin
            in_status = STATUS_RANGE;
        end else begin
            in_status = STATUS_OK;
        end
    end

    spwm_codec u_codec (
        .codeword  (rd_data_reg),
        .kind      (kind_reg),
        .offset    (off_reg),
        .wdata     (wdata_reg),
        .raw_check (raw_reg),
        .result    (codec)
    );

    assign ok        = (status_reg == STATUS_OK);
    assign is_decode = ok && (kind_reg inside {[KIND_WR_HALF:KIND_RD_BYTE]});
    assign is_write  = ok && (kind_reg inside {KIND_WR_WORD, KIND_WR_HALF,
                                               KIND_WR_BYTE, KIND_RAW});
    assign is_read   = ok && (kind_reg inside {KIND_RD_WORD, KIND_RD_HALF, KIND_RD_BYTE});

    assign mem_re    = accept && (in_status == STATUS_OK);
    assign mem_raddr = in_addr[AW+1:2];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = codec.codeword;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end else if (exec_fire && is_write) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        off_next     = off_reg;
        wdata_next   = wdata_reg;
        raw_next     = raw_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        rdata_next   = rdata_reg;
        ostat_next   = ostat_reg;
        cor_next     = cor_reg;
        det_next     = det_reg;
        cor_cnt_next = cor_cnt_reg;
        det_cnt_next = det_cnt_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == AW'(WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    kind_next   = in_kind;
                    idx_next    = in_addr[AW+1:2];
                    off_next    = in_addr[1:0];
                    wdata_next  = s_tdata[63:32];
                    raw_next    = s_tdata[70:64];
                    status_next = in_status;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    rdata_next   = is_read ? codec.rdata : '0;
                    ostat_next   = status_reg;
                    cor_next     = is_decode && codec.corrected;
                    det_next     = is_decode && codec.detected;
                    cor_cnt_next = cor_cnt_reg + 32'(is_decode && codec.corrected);
                    det_cnt_next = det_cnt_reg + 32'(is_decode && codec.detected);
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
            cor_cnt_reg <= '0;
            det_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
            cor_cnt_reg <= cor_cnt_next;
            det_cnt_reg <= det_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        idx_reg    <= idx_next;
        off_reg    <= off_next;
        wdata_reg  <= wdata_next;
        raw_reg    <= raw_next;
        status_reg <= status_next;
        rdata_reg  <= rdata_next;
        ostat_reg  <= ostat_next;
        cor_reg    <= cor_next;
        det_reg    <= det_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, det_cnt_reg, cor_cnt_reg, det_reg, cor_reg, ostat_reg, rdata_reg};

endmodule

@@ tb/secded_protected_word_memory_checker.sv @@
// checker for the secded word memory: predicts each result word from accepted input words
module secded_protected_word_memory_checker #(
    parameter int WORDS = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [71:0]  s_tdata,   // addr, wdata, raw_check, zero pad
    input  logic [2:0]   s_tuser,   // kind
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,   // rdata, status, corrected, detected,
                                    // correction_total, detection_total, zero pad
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import spwm_pkg::*;

    localparam int AW = $clog2(WORDS);

    // packed from the top bit down, so rdata lands in the lowest bits
    typedef struct packed {
        logic [31:0] detection_total;
        logic [31:0] correction_total;
        logic        detected;
        logic        corrected;
        logic [1:0]  status;
        logic [31:0] rdata;
    } mem_result_t;

    logic [38:0] cw_mem [WORDS];
    logic [31:0] correction_count;
    logic [31:0] detection_count;
    mem_result_t expected_q [$];

    initial begin
        fail_count = 0;
        pending = 0;
    end

    // data bit n sits at the n-th position that is not a power of two, from 3 up
    function automatic logic [5:0] ham_syndrome_of(input logic [31:0] d);
        logic [5:0] h;
        int n;
        h = '0;
        n = 0;
        for (int p = 3; n < 32; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (d[n]) begin
                    h = h ^ p[5:0];
                end
                n++;
            end
        end
        return h;
    endfunction

    function automatic logic [38:0] codeword_of(input logic [31:0] d);
        logic [5:0] h;
        h = ham_syndrome_of(d);
        return {(^d) ^ (^h), h, d};
    endfunction

    function automatic void recover_data(input logic [38:0] cw, output logic [31:0] d,
                                         output logic cor, output logic det);
        logic [5:0] syn;
        logic       odd;
        int         n;
        d = cw[31:0];
        syn = ham_syndrome_of(d) ^ cw[37:32];
        odd = (^cw[31:0]) ^ (^cw[37:32]) ^ cw[38];
        cor = 1'b0;
        det = 1'b0;
        n = 0;
        if (syn == '0 && !odd) begin
            return;
        end
        if (!odd || syn > SYN_MAX) begin
            det = 1'b1;
            return;
        end
        cor = 1'b1;
        for (int p = 3; n < 32; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (p[5:0] == syn) begin
                    d[n] = ~d[n];
                end
                n++;
            end
        end
    endfunction

    function automatic mem_result_t predict_access(input logic [2:0] kind,
                                                   input logic [31:0] addr,
                                                   input logic [31:0] wdata,
                                                   input logic [6:0] rawc);
        mem_result_t res;
        logic [1:0]  mask;
        logic [31:0] idx;
        logic [31:0] d;
        logic        cor;
        logic        det;
        int          sh;
        res = '0;
        mask = 2'b00;
        if (kind == KIND_WR_WORD || kind == KIND_RD_WORD || kind == KIND_RAW) begin
            mask = 2'b11;
        end else if (kind == KIND_WR_HALF || kind == KIND_RD_HALF) begin
            mask = 2'b01;
        end
        idx = addr >> 2;
        if (kind <= KIND_RAW) begin
            if ((addr[1:0] & mask) != 2'b00) begin
                res.status = STATUS_MISALIGN;
            end else if (idx >= WORDS) begin
                res.status = STATUS_RANGE;
            end else if (kind == KIND_WR_WORD) begin
                cw_mem[idx[AW-1:0]] = codeword_of(wdata);
            end else if (kind == KIND_RAW) begin
                cw_mem[idx[AW-1:0]] = {rawc, wdata};
            end else begin
                recover_data(cw_mem[idx[AW-1:0]], d, cor, det);
                res.corrected = cor;
                res.detected = det;
                if (cor) begin
                    correction_count++;
                end
                if (det) begin
                    detection_count++;
                end
                case (kind)
                    KIND_WR_HALF: begin
                        sh = addr[1] * 16;
                        d[sh +: 16] = wdata[15:0];
                        cw_mem[idx[AW-1:0]] = codeword_of(d);
                    end
                    KIND_WR_BYTE: begin
                        sh = addr[1:0] * 8;
                        d[sh +: 8] = wdata[7:0];
                        cw_mem[idx[AW-1:0]] = codeword_of(d);
                    end
                    KIND_RD_WORD: begin
                        res.rdata = d;
                    end
                    KIND_RD_HALF: begin
                        sh = addr[1] * 16;
                        res.rdata = {16'h0000, d[sh +: 16]};
                    end
                    default: begin
                        sh = addr[1:0] * 8;
                        res.rdata = {24'h000000, d[sh +: 8]};
                    end
                endcase
            end
        end
        res.correction_total = correction_count;
        res.detection_total = detection_count;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, want);
    endtask

    task automatic compare_result(input mem_result_t got, input mem_result_t want);
        if (got.rdata !== want.rdata) begin
            report_mismatch("rdata", got.rdata, want.rdata);
        end
        if (got.status !== want.status) begin
            report_mismatch("status", got.status, want.status);
        end
        if (got.corrected !== want.corrected) begin
            report_mismatch("corrected", got.corrected, want.corrected);
        end
        if (got.detected !== want.detected) begin
            report_mismatch("detected", got.detected, want.detected);
        end
        if (got.correction_total !== want.correction_total) begin
            report_mismatch("correction_total", got.correction_total, want.correction_total);
        end
        if (got.detection_total !== want.detection_total) begin
            report_mismatch("detection_total", got.detection_total, want.detection_total);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WORDS; i++) begin
                cw_mem[AW'(i)] = '0;
            end
            correction_count = '0;
            detection_count = '0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("word with nothing expected", m_tdata[31:0], '0);
                end else begin
                    compare_result(m_tdata[99:0], expected_q.pop_front());
                end
            end
            if (s_tvalid && s_tready) begin
                expected_q.push_back(predict_access(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                                    s_tdata[70:64]));
            end
        end
        pending <= expected_q.size();
    end

endmodule

@@ tb/tb_secded_protected_word_memory_core.sv @@
// testbench top for the secded word memory: clock, reset, stimulus and verdict
module tb_secded_protected_word_memory_core;
    timeunit 1ns;
    timeprecision 1ps;

    import spwm_pkg::*;

    localparam int ENTRY_COUNT = 1024;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 8;
    localparam int PHASE_WORDS = 95;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int fail_count;
    int pending;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    secded_protected_word_memory_core #(
        .WORDS(ENTRY_COUNT)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    secded_protected_word_memory_checker #(
        .WORDS(ENTRY_COUNT)
    ) u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .fail_count(fail_count),
        .pending(pending)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_secded_protected_word_memory_core NOT OK");
            $finish;
        end
    end

    // parity and hamming bits for building raw codewords
    function automatic logic [6:0] check_bits(input logic [31:0] d);
        logic [5:0] h;
        int n;
        h = '0;
        n = 0;
        for (int p = 3; n < 32; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (d[n]) begin
                    h = h ^ p[5:0];
                end
                n++;
            end
        end
        return {(^d) ^ (^h), h};
    endfunction

    task automatic send_word(input logic [2:0] kind, input logic [31:0] addr,
                             input logic [31:0] wdata, input logic [6:0] rawc);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {1'b0, rawc, wdata, addr};
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic send_raw(input logic [31:0] addr, input logic [31:0] d,
                            input logic [38:0] flips);
        logic [38:0] cw;
        cw = {check_bits(d), d} ^ flips;
        send_word(KIND_RAW, addr, cw[31:0], cw[38:32]);
    endtask

    task automatic send_random();
        logic [2:0]  kind;
        logic [1:0]  mask;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [6:0]  rawc;
        logic [38:0] cw;
        int r;
        int k;
        int p;
        int q;
        r = $urandom_range(99);
        k = $urandom_range(99);
        kind = k < 14 ? KIND_WR_WORD : k < 26 ? KIND_WR_HALF : k < 38 ? KIND_WR_BYTE :
               k < 56 ? KIND_RD_WORD : k < 68 ? KIND_RD_HALF : k < 80 ? KIND_RD_BYTE :
               KIND_RAW;
        if (r < 3) begin
            kind = KIND_UNUSED;
        end else if (r < 8 && (kind == KIND_WR_BYTE || kind == KIND_RD_BYTE)) begin
            kind = KIND_RD_HALF;
        end
        mask = 2'b00;
        if (kind == KIND_WR_WORD || kind == KIND_RD_WORD || kind == KIND_RAW) begin
            mask = 2'b11;
        end else if (kind == KIND_WR_HALF || kind == KIND_RD_HALF) begin
            mask = 2'b01;
        end
        wdata = $urandom;
        rawc = 7'($urandom_range(127));
        if (r < 3) begin
            addr = $urandom;
        end else if (r < 8) begin
            addr = $urandom;
            if (mask == 2'b11) begin
                addr[1:0] = 2'($urandom_range(3, 1));
            end else begin
                addr[0] = 1'b1;
            end
        end else if (r < 14) begin
            addr = $urandom_range(32'hFFFF_FFFF, ENTRY_COUNT * 4);
            addr[1:0] = addr[1:0] & ~mask;
        end else begin
            addr = ($urandom_range(3) == 0 ? $urandom_range(ENTRY_COUNT - 1)
                                          : $urandom_range(15)) * 4;
            addr[1:0] = 2'($urandom_range(3)) & ~mask;
            if (kind == KIND_RAW) begin
                // mostly single and double upsets of a valid codeword
                cw = {check_bits(wdata), wdata};
                k = $urandom_range(99);
                p = $urandom_range(38);
                q = (p + 1 + $urandom_range(37)) % 39;
                if (k >= 15 && k < 90) begin
                    cw[p] = ~cw[p];
                end
                if (k >= 60 && k < 90) begin
                    cw[q] = ~cw[q];
                end
                if (k >= 90) begin
                    cw[38:32] = rawc;
                end
                wdata = cw[31:0];
                rawc = cw[38:32];
            end
        end
        send_word(kind, addr, wdata, rawc);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(KIND_RD_WORD, 32'h0, 32'h0, 7'h0);
        send_word(KIND_WR_WORD, 32'h0, 32'hFFFF_FFFF, 7'h0);
        send_word(KIND_RD_WORD, 32'h0, 32'h0, 7'h0);
        send_word(KIND_WR_WORD, (ENTRY_COUNT - 1) * 4, 32'h0, 7'h7F);
        send_word(KIND_WR_WORD, ENTRY_COUNT * 4, 32'h1234_5678, 7'h0);
        send_word(KIND_RD_BYTE, 32'hFFFF_FFFF, 32'h0, 7'h0);
        send_word(KIND_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F);
        send_word(KIND_WR_WORD, 32'h2, 32'h0, 7'h0);
        send_word(KIND_RD_HALF, 32'h1, 32'h0, 7'h0);
        send_word(KIND_WR_HALF, 32'h2, 32'hABCD_1234, 7'h0);
        send_word(KIND_RD_HALF, 32'h2, 32'h0, 7'h0);
        send_word(KIND_WR_BYTE, 32'h3, 32'h0000_005A, 7'h0);
        send_word(KIND_RD_BYTE, 32'h3, 32'h0, 7'h0);
        // flipped parity bit, then flipped check bit, then flipped data bit
        send_raw(32'h4, 32'h1234_5678, 39'h1 << 38);
        send_word(KIND_RD_WORD, 32'h4, 32'h0, 7'h0);
        send_raw(32'h8, 32'h8765_4321, 39'h1 << 32);
        send_word(KIND_RD_BYTE, 32'h9, 32'h0, 7'h0);
        send_raw(32'hC, 32'hDEAD_BEEF, 39'h1 << 5);
        send_word(KIND_RD_HALF, 32'hE, 32'h0, 7'h0);
        // double upset, then a half write that merges into uncorrected data
        send_raw(32'h10, 32'hCAFE_F00D, 39'h81);
        send_word(KIND_WR_HALF, 32'h10, 32'h0000_BEEF, 7'h0);
        send_word(KIND_RD_WORD, 32'h10, 32'h0, 7'h0);
        // syndrome past the last position with odd parity
        send_raw(32'h14, 32'h0F0F_0F0F, (39'h1 << 31) | (39'h1 << 32) | (39'h1 << 38));
        send_word(KIND_RD_WORD, 32'h14, 32'h0, 7'h0);
        send_word(KIND_UNUSED, 32'h0, 32'hFFFF_FFFF, 7'h7F);

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 54 : (phase == 3) ? 21 : 0;
            stall_pct = (phase == 2) ? 54 : (phase == 3) ? 21 : 0;
            repeat (PHASE_WORDS) send_random();
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_secded_protected_word_memory_core OK");
        end else begin
            $display("tb_secded_protected_word_memory_core NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/spwm_pkg.sv
sv/spwm_codec.sv
sv/secded_protected_word_memory_core.sv
tb/secded_protected_word_memory_checker.sv
tb/tb_secded_protected_word_memory_core.sv
